// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the frame delimiter RTL.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define MFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/mfd_pkg.sv =====
// Shared types, constants and lookup functions for the Modbus frame delimiter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mfd_pkg;

  localparam int unsigned CntW = 9;   // frame counters and lengths
  localparam int unsigned CrcW = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register reset values.
  localparam logic [2:0]      HEADER_LEN_RST   = 3'd1;
  localparam logic [1:0]      CHECKSUM_LEN_RST = 2'd2;
  localparam logic [CntW-1:0] MAX_FRAME_RST    = 9'd256;
  localparam logic            EXPECT_REQ_RST   = 1'b1;

  typedef enum logic [1:0] {
    CFG_HEADER_LEN   = 2'd0,
    CFG_CHECKSUM_LEN = 2'd1,
    CFG_MAX_FRAME    = 2'd2,
    CFG_EXPECT_REQ   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_META = 3'b010,
    PH_DATA = 3'b100
  } phase_e;

  typedef struct packed {
    logic [2:0]      header_len;
    logic [1:0]      checksum_len;
    logic [CntW-1:0] max_frame;
    logic            expect_req;
  } cfg_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [CntW-1:0] pos;
    logic [CntW-1:0] len;
    logic [CrcW-1:0] crc;
  } res_t;

  // One entry of the reflected CRC-16 table (poly 0xA001).
  function automatic logic [15:0] crc_table(input logic [7:0] idx);
    logic [15:0] s;
    s = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      s = s[0] ? ((s >> 1) ^ CRC_POLY) : (s >> 1);
    end
    return s;
  endfunction

  // Meta bytes that follow the function code.
  function automatic logic [3:0] meta_len(input logic [7:0] fc, input logic req);
    logic [3:0] m;
    if (req) begin
      if (fc <= 8'd6)                     m = 4'd4;
      else if (fc == 8'd15 || fc == 8'd16) m = 4'd5;
      else if (fc == 8'd22)               m = 4'd6;
      else if (fc == 8'd23)               m = 4'd9;
      else                                m = 4'd0;
    end else begin
      if (fc == 8'd5 || fc == 8'd6 || fc == 8'd15 || fc == 8'd16) m = 4'd4;
      else if (fc == 8'd22)                                       m = 4'd6;
      else                                                        m = 4'd1;
    end
    return m;
  endfunction

  // Whether the last meta byte is a byte count for the data section.
  function automatic logic has_count(input logic [7:0] fc, input logic req);
    logic c;
    if (req) c = (fc == 8'd15) || (fc == 8'd16) || (fc == 8'd23);
    else     c = (fc <= 8'd4) || (fc == 8'd17) || (fc == 8'd23);
    return c;
  endfunction

endpackage

// ===== hdl/modbus_frame_delimiter_crc_unit.sv =====
// A byte transferred in waits in the input register; its result is then loaded into the result
// register for the master side. One byte per cycle while results are taken; the parse state and
// CRC table step are combinational. The input and result registers each hold one transfer, so
// the slave side keeps accepting while a finished result waits, as long as the result is taken.
// Reset (rst_ni low, asynchronous): registers return to defaults, parser at frame start,
// CRC 0xFFFF, both stages empty. Depends on mfd_pkg, mfd_parser; includes assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modbus_frame_delimiter_crc_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [8:0]  cfg_wdata_i,
  // Slave side: received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] restart
  // Master side: per-byte results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [8:0] byte_position, [17:9] frame_length,
                                      // [33:18] running_crc, [39:34] zero
  output logic        m_axis_tlast,   // frame_done
  output logic        m_axis_tuser    // [0] overflow_error
);

  mfd_pkg::cfg_t cfg_q;
  mfd_pkg::res_t res;
  mfd_pkg::res_t out_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_restart_q;
  logic       out_valid_q;
  logic       advance;

  // Configuration registers: to be written only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_len   <= mfd_pkg::HEADER_LEN_RST;
      cfg_q.checksum_len <= mfd_pkg::CHECKSUM_LEN_RST;
      cfg_q.max_frame    <= mfd_pkg::MAX_FRAME_RST;
      cfg_q.expect_req   <= mfd_pkg::EXPECT_REQ_RST;
    end else if (cfg_we_i) begin
      unique case (mfd_pkg::cfg_idx_e'(cfg_addr_i))
        mfd_pkg::CFG_HEADER_LEN:   cfg_q.header_len   <= cfg_wdata_i[2:0];
        mfd_pkg::CFG_CHECKSUM_LEN: cfg_q.checksum_len <= cfg_wdata_i[1:0];
        mfd_pkg::CFG_MAX_FRAME:    cfg_q.max_frame    <= cfg_wdata_i;
        mfd_pkg::CFG_EXPECT_REQ:   cfg_q.expect_req   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Advance the held byte into the parser whenever the result register is free
  // or is being drained in this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input payload: capture on each transfer in.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
  end

  mfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .restart_i (in_restart_q),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  // Result register: load on advance, drop once the master side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.crc, out_q.len, out_q.pos};
  assign m_axis_tlast  = out_q.done;
  assign m_axis_tuser  = out_q.ovf;

  // Overflow always closes the frame.
  `MFD_ASSERT(a_ovf_ends_frame, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast,
              "overflow result without frame end")
  // Length so far is always the position plus this byte.
  `MFD_ASSERT(a_len_tracks_pos,
              m_axis_tvalid |-> m_axis_tdata[17:9] == (m_axis_tdata[8:0] + 9'd1),
              "frame length does not follow byte position")

endmodule

// ===== hdl/mfd_crc_step.sv =====
// One byte step of CRC-16/Modbus kept in byte-swapped (table) form.
// Depends on mfd_pkg for the table function.
`timescale 1ns / 1ps

module mfd_crc_step (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  logic [15:0] tab;

  // Standard CRC low byte sits in crc_i[15:8].
  assign tab   = mfd_pkg::crc_table(crc_i[15:8] ^ byte_i);
  assign crc_o = {crc_i[7:0] ^ tab[7:0], tab[15:8]};

endmodule

// ===== hdl/mfd_parser.sv =====
// Frame parse state and per-byte decision logic.
// Depends on mfd_pkg and mfd_crc_step; includes assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                restart_i,
  input  mfd_pkg::cfg_t       cfg_i,
  output mfd_pkg::res_t       res_o
);

  mfd_pkg::phase_e           phase_q, phase_d, phase_b;
  logic [mfd_pkg::CntW-1:0]  rem_q, rem_d, rem_b, rem_dec, rem_start;
  logic [mfd_pkg::CntW-1:0]  cnt_q, cnt_d, cnt_b, cnt_n;
  logic [7:0]                fc_q, fc_d;
  logic [15:0]               crc_q, crc_d, crc_b, crc_n;
  logic [3:0]                meta;
  logic [mfd_pkg::CntW-1:0]  dlen;
  logic [mfd_pkg::CntW:0]    total;
  logic                      decide, done, ovf;

  assign rem_start = {6'd0, cfg_i.header_len} + 9'd1;

  mfd_crc_step u_crc (
    .crc_i  (crc_b),
    .byte_i (byte_i),
    .crc_o  (crc_n)
  );

  always_comb begin
    phase_b = restart_i ? mfd_pkg::PH_HEAD : phase_q;
    rem_b   = restart_i ? rem_start : rem_q;
    cnt_b   = restart_i ? '0 : cnt_q;
    crc_b   = restart_i ? mfd_pkg::CRC_INIT : crc_q;

    cnt_n   = cnt_b + 9'd1;
    rem_dec = (rem_b != '0) ? rem_b - 9'd1 : '0;
    meta    = mfd_pkg::meta_len(byte_i, cfg_i.expect_req);

    phase_d = phase_b;
    rem_d   = rem_dec;
    fc_d    = fc_q;
    decide  = 1'b0;
    done    = 1'b0;
    ovf     = 1'b0;

    if (rem_dec == '0) begin
      priority if (phase_b == mfd_pkg::PH_META) begin
        decide = 1'b1;
      end else if (phase_b == mfd_pkg::PH_DATA) begin
        done = 1'b1;
      end else begin
        fc_d = byte_i;
        if (meta != 4'd0) begin
          phase_d = mfd_pkg::PH_META;
          rem_d   = {5'd0, meta};
        end else begin
          decide = 1'b1;
        end
      end
    end

    // Data length: byte count only when decided on the last meta byte.
    dlen = ((phase_b == mfd_pkg::PH_META && mfd_pkg::has_count(fc_q, cfg_i.expect_req))
            ? {1'b0, byte_i} : 9'd0) + {7'd0, cfg_i.checksum_len};
    total = {1'b0, cnt_n} + {1'b0, dlen};

    if (decide) begin
      if (total > {1'b0, cfg_i.max_frame}) begin
        ovf  = 1'b1;
        done = 1'b1;
      end else begin
        phase_d = mfd_pkg::PH_DATA;
        rem_d   = dlen;
        if (dlen == '0) done = 1'b1;
      end
    end

    if (done) begin
      phase_d = mfd_pkg::PH_HEAD;
      rem_d   = rem_start;
      cnt_d   = '0;
      crc_d   = mfd_pkg::CRC_INIT;
    end else begin
      cnt_d   = cnt_n;
      crc_d   = crc_n;
    end

    res_o.done = done;
    res_o.ovf  = ovf;
    res_o.pos  = cnt_b;
    res_o.len  = cnt_n;
    res_o.crc  = crc_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mfd_pkg::PH_HEAD;
      rem_q   <= {6'd0, mfd_pkg::HEADER_LEN_RST} + 9'd1;
      cnt_q   <= '0;
      fc_q    <= '0;
      crc_q   <= mfd_pkg::CRC_INIT;
    end else if (step_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      fc_q    <= fc_d;
      crc_q   <= crc_d;
    end
  end

  // A loaded count is never zero: every frame path reloads at least one byte.
  `MFD_ASSERT(a_rem_nonzero, rem_q != '0, "bytes remaining dropped to zero")
  // A finished frame restarts the byte counter.
  `MFD_ASSERT(a_done_clears_cnt, step_i && res_o.done |=> cnt_q == '0,
              "frame count not cleared after frame end")

endmodule

// ===== tb/sv/tb_modbus_frame_delimiter_crc_unit.sv =====
// Self-checking bench for modbus_frame_delimiter_crc_unit: Modbus bytes in, one result per byte.
// Predicts frame ends, overflow, positions and CRC per byte; uses mfd_pkg types and indexes.
`timescale 1ns / 1ps

module tb_modbus_frame_delimiter_crc_unit;
  import mfd_pkg::*;

  localparam int CLK_HALF           = 5;
  localparam int CYCLE_LIMIT        = 100000;
  localparam int SETTLE_CYCLES      = 4;    // margin after the last result is taken
  localparam int RANDOM_PER_SETTING = 216;
  localparam int NUM_SETTINGS       = 8;
  localparam int NUM_DIRECTED       = 22;
  localparam int LONG_HOLD          = 60;
  localparam int MAX_REPORTS        = 200;

  // Modbus function codes the delimiter knows about.
  localparam logic [7:0] FC_NONE          = 8'd0;
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
  localparam logic [7:0] FC_REPORT_ID     = 8'd17;
  localparam logic [7:0] FC_MASK_WRITE    = 8'd22;
  localparam logic [7:0] FC_READ_WRITE    = 8'd23;
  localparam logic [7:0] FC_EXCEPTION_BIT = 8'h80;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [2:0] hdr;
    logic [1:0] csum;
    logic [8:0] maxlen;
    logic       req;
    idle_mode_e idle;
  } setting_t;

  // One row of the directed table; typed rows carry a hand-read expectation.
  typedef struct packed {
    logic       rs;
    logic [7:0] b;
    logic       typed;
    logic       done;
    logic       ovf;
    logic [8:0] pos;
    logic [8:0] len;
  } row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_addr_i    = CFG_HEADER_LEN;
  logic [8:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  modbus_frame_delimiter_crc_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame predictor: its own copy of the registers and the parse state.
  // ---------------------------------------------------------------------------
  logic [2:0]  hdr_len;
  logic [1:0]  csum_len;
  logic [8:0]  max_len;
  logic        req_mode;
  phase_e      ph;
  int unsigned left_cnt;
  logic [8:0]  byte_cnt;
  logic [7:0]  fcode;
  logic [15:0] crc_acc;

  res_t expected_results[$];   // one per transferred byte, oldest first

  int send_pct;
  int recv_pct;
  int hold_request;
  int errors;
  int bytes_sent;
  int results_seen;
  int frames_closed;
  int overflows;
  int cycles;
  bit resync;

  // CRC-16/Modbus kept byte-swapped: standard low byte sits in the upper half.
  function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] s;
    s = {acc[7:0], acc[15:8]} ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      s = s[0] ? ((s >> 1) ^ CRC_POLY) : (s >> 1);
    end
    return {s[7:0], s[15:8]};
  endfunction

  // Bytes between the function code and the data section.
  function automatic int meta_bytes(input logic [7:0] fc, input logic req);
    if (req) begin
      case (fc)
        FC_WRITE_COILS, FC_WRITE_REGS: return 5;
        FC_MASK_WRITE:                 return 6;
        FC_READ_WRITE:                 return 9;
        default:                       return (fc <= FC_WRITE_REG) ? 4 : 0;
      endcase
    end
    case (fc)
      FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: return 4;
      FC_MASK_WRITE:                                              return 6;
      default:                                                    return 1;
    endcase
  endfunction

  // True when the last meta byte announces the data length.
  function automatic bit count_follows(input logic [7:0] fc, input logic req);
    if (req) return fc == FC_WRITE_COILS || fc == FC_WRITE_REGS || fc == FC_READ_WRITE;
    return fc <= FC_READ_INPUT || fc == FC_REPORT_ID || fc == FC_READ_WRITE;
  endfunction

  function automatic void open_frame();
    ph       = PH_HEAD;
    left_cnt = hdr_len + 1;
    byte_cnt = '0;
    crc_acc  = CRC_INIT;
  endfunction

  // Advance the parse state by one byte and return what the block must show for it.
  function automatic res_t predict_byte(input logic rs, input logic [7:0] b);
    res_t        r;
    logic [8:0]  pos;
    int unsigned tail;
    bit          fin;
    bit          ovf;
    bit          decide;
    fin    = 0;
    ovf    = 0;
    decide = 0;
    if (rs) open_frame();
    pos      = byte_cnt;
    byte_cnt = byte_cnt + 9'd1;
    crc_acc  = crc_update(crc_acc, b);
    if (left_cnt > 0) left_cnt--;
    if (left_cnt == 0) begin
      if (ph == PH_HEAD) begin
        fcode = b;
        if (meta_bytes(fcode, req_mode) != 0) begin
          ph       = PH_META;
          left_cnt = meta_bytes(fcode, req_mode);
        end else begin
          decide = 1;
        end
      end else if (ph == PH_META) begin
        decide = 1;
      end else begin
        fin = 1;
      end
    end
    if (decide) begin
      // Full length is known now: check it against the limit.
      tail = 0;
      if (ph == PH_META && count_follows(fcode, req_mode)) tail = b;
      tail += csum_len;
      if (byte_cnt + tail > max_len) begin
        ovf = 1;
        fin = 1;
      end else begin
        ph       = PH_DATA;
        left_cnt = tail;
        if (tail == 0) fin = 1;
      end
    end
    r.done = fin;
    r.ovf  = ovf;
    r.pos  = pos;
    r.len  = byte_cnt;
    r.crc  = crc_acc;
    if (fin) open_frame();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Slave side: byte transfers, register writes, drain.
  // ---------------------------------------------------------------------------

  // Offer one byte after a random gap and hold it until the transfer happens.
  task automatic send_byte(input logic rs, input logic [7:0] b, output res_t r);
    int gap;
    gap = 0;
    while (send_pct > 0 && $urandom_range(99) < send_pct && gap < 40) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= rs;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_byte(rs, b);
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers back to back; only called while the block is idle.
  task automatic load_setting(input setting_t st);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_HEADER_LEN;
    cfg_wdata_i <= {6'd0, st.hdr};
    @(posedge clk_i);
    cfg_addr_i  <= CFG_CHECKSUM_LEN;
    cfg_wdata_i <= {7'd0, st.csum};
    @(posedge clk_i);
    cfg_addr_i  <= CFG_MAX_FRAME;
    cfg_wdata_i <= st.maxlen;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_EXPECT_REQ;
    cfg_wdata_i <= {8'd0, st.req};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    // A header count already loaded stays; only the registers change here.
    hdr_len  = st.hdr;
    csum_len = st.csum;
    max_len  = st.maxlen;
    req_mode = st.req;
    send_pct = (st.idle == IDLE_SEND) ? 78 : (st.idle == IDLE_BOTH) ? 9 : 0;
    recv_pct = (st.idle == IDLE_RECV) ? 78 : (st.idle == IDLE_BOTH) ? 9 : 0;
  endtask

  // Register settings walked by the random part, extremes included.
  function automatic setting_t setting_at(input int i);
    case (i)
      0:       return '{3'd1, 2'd2, 9'd256, 1'b1, IDLE_NONE};  // serial requests
      1:       return '{3'd1, 2'd2, 9'd256, 1'b0, IDLE_SEND};  // serial responses
      2:       return '{3'd7, 2'd0, 9'd260, 1'b1, IDLE_RECV};  // TCP requests, 260-byte limit
      3:       return '{3'd7, 2'd0, 9'd260, 1'b0, IDLE_BOTH};  // TCP responses
      4:       return '{3'd0, 2'd3, 9'd511, 1'b1, IDLE_NONE};  // no header, 3-byte checksum
      5:       return '{3'd2, 2'd1, 9'd0,   1'b0, IDLE_SEND};  // zero limit flags every check
      6:       return '{3'd3, 2'd2, 9'd24,  1'b1, IDLE_RECV};  // tight limit
      default: return '{3'd4, 2'd3, 9'd1,   1'b0, IDLE_BOTH};  // one-byte limit
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(13))
      0:       return FC_READ_COILS;
      1:       return FC_READ_DISCRETE;
      2:       return FC_READ_HOLDING;
      3:       return FC_READ_INPUT;
      4:       return FC_WRITE_COIL;
      5:       return FC_WRITE_REG;
      6:       return FC_WRITE_COILS;
      7:       return FC_WRITE_REGS;
      8:       return FC_REPORT_ID;
      9:       return FC_MASK_WRITE;
      10:      return FC_READ_WRITE;
      11:      return FC_NONE;
      12:      return FC_EXCEPTION_BIT | 8'($urandom_range(23, 1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly short data sections, now and then a long one.
  function automatic int pick_count();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(12);
    if (sel < 95) return $urandom_range(60, 13);
    return $urandom_range(255, 61);
  endfunction

  // Build one frame for the current mode, or a short burst of noise, and send it.
  task automatic send_random_frame();
    logic [7:0] fr[$];
    logic [7:0] fc;
    int         m;
    int         cnt;
    bit         noise;
    logic       rs;
    res_t       r;
    noise = ($urandom_range(99) < 10);
    cnt   = 0;
    if (noise) begin
      repeat ($urandom_range(12, 1)) fr.push_back(8'($urandom_range(255)));
    end else begin
      repeat (hdr_len) fr.push_back(8'($urandom_range(255)));
      fc = pick_code();
      fr.push_back(fc);
      m = meta_bytes(fc, req_mode);
      for (int k = 0; k < m; k++) begin
        if (k == m - 1 && count_follows(fc, req_mode)) begin
          cnt = pick_count();
          fr.push_back(8'(cnt));
        end else begin
          fr.push_back(8'($urandom_range(255)));
        end
      end
      repeat (cnt + csum_len) fr.push_back(8'($urandom_range(255)));
    end
    foreach (fr[k]) begin
      if (k == 0 && !noise) begin
        // Realign with restart when the parser is not at a clean frame start.
        rs = resync || byte_cnt != 0 || $urandom_range(99) < 30;
      end else begin
        rs = ($urandom_range(99) < (noise ? 20 : 2));
      end
      if (rs) resync = 0;
      send_byte(rs, fr[k], r);
      expected_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Master side: take results, stall at random, compare with the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
               results_seen, field, got, want);
  endtask

  task automatic check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("transfer with nothing expected", m_axis_tdata[31:0], 0);
      return;
    end
    want = expected_results.pop_front();
    if (m_axis_tlast !== want.done)        report_mismatch("frame_done", m_axis_tlast, want.done);
    if (m_axis_tuser !== want.ovf)         report_mismatch("overflow_error", m_axis_tuser, want.ovf);
    if (m_axis_tdata[8:0] !== want.pos)    report_mismatch("byte_position", m_axis_tdata[8:0],
                                                           want.pos);
    if (m_axis_tdata[17:9] !== want.len)   report_mismatch("frame_length", m_axis_tdata[17:9],
                                                           want.len);
    if (m_axis_tdata[33:18] !== want.crc)  report_mismatch("running_crc", m_axis_tdata[33:18],
                                                           want.crc);
    if (m_axis_tdata[39:34] !== 6'd0)      report_mismatch("tdata pad", m_axis_tdata[39:34], 0);
    if (want.done) frames_closed++;
    if (want.ovf) overflows++;
    results_seen++;
  endtask

  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
      // A long hold-off lets the block fill up and push back on the slave side.
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table at reset defaults, then random per setting.
  // ---------------------------------------------------------------------------
  row_t dir_rows[NUM_DIRECTED];

  function automatic row_t free_row(input logic rs, input logic [7:0] b);
    return '{rs, b, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0};
  endfunction

  function automatic row_t typed_row(input logic rs, input logic [7:0] b, input logic done,
                                     input logic ovf, input logic [8:0] pos,
                                     input logic [8:0] len);
    return '{rs, b, 1'b1, done, ovf, pos, len};
  endfunction

  initial begin : stimulus
    res_t     r;
    setting_t st;
    int       start;
    bit       hold_done;
    bit       pause_done;

    errors        = 0;
    bytes_sent    = 0;
    results_seen  = 0;
    frames_closed = 0;
    overflows     = 0;
    cycles        = 0;
    send_pct      = 0;
    recv_pct      = 0;
    hold_request  = 0;
    hold_done     = 0;
    pause_done    = 0;
    resync        = 0;

    // Predictor starts from the register reset values.
    hdr_len  = HEADER_LEN_RST;
    csum_len = CHECKSUM_LEN_RST;
    max_len  = MAX_FRAME_RST;
    req_mode = EXPECT_REQ_RST;
    fcode    = '0;
    open_frame();

    // Read holding registers request: four meta bytes, no count, two CRC bytes.
    dir_rows[0]  = typed_row(1'b1, 8'h01, 1'b0, 1'b0, 9'd0, 9'd1);
    dir_rows[1]  = free_row(1'b0, FC_READ_HOLDING);
    dir_rows[2]  = free_row(1'b0, 8'h00);
    dir_rows[3]  = free_row(1'b0, 8'h00);
    dir_rows[4]  = free_row(1'b0, 8'h00);
    dir_rows[5]  = free_row(1'b0, 8'h0A);
    dir_rows[6]  = free_row(1'b0, 8'hC5);
    dir_rows[7]  = typed_row(1'b0, 8'hCD, 1'b1, 1'b0, 9'd7, 9'd8);
    // Write multiple registers announcing 255 data bytes: length overflow at the count.
    dir_rows[8]  = typed_row(1'b0, 8'h01, 1'b0, 1'b0, 9'd0, 9'd1);
    dir_rows[9]  = free_row(1'b0, FC_WRITE_REGS);
    dir_rows[10] = free_row(1'b0, 8'h00);
    dir_rows[11] = free_row(1'b0, 8'h01);
    dir_rows[12] = free_row(1'b0, 8'h00);
    dir_rows[13] = free_row(1'b0, 8'h02);
    dir_rows[14] = typed_row(1'b0, 8'hFF, 1'b1, 1'b1, 9'd6, 9'd7);
    // Partial read/write frame dropped by restart, then an unknown code with no meta.
    dir_rows[15] = free_row(1'b0, 8'h01);
    dir_rows[16] = free_row(1'b0, FC_READ_WRITE);
    dir_rows[17] = free_row(1'b0, 8'h00);
    dir_rows[18] = typed_row(1'b1, 8'h01, 1'b0, 1'b0, 9'd0, 9'd1);
    dir_rows[19] = free_row(1'b0, 8'hFF);
    dir_rows[20] = free_row(1'b0, 8'h12);
    dir_rows[21] = typed_row(1'b0, 8'h34, 1'b1, 1'b0, 9'd3, 9'd4);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].rs, dir_rows[i].b, r);
      if (dir_rows[i].typed) begin
        r.done = dir_rows[i].done;
        r.ovf  = dir_rows[i].ovf;
        r.pos  = dir_rows[i].pos;
        r.len  = dir_rows[i].len;
      end
      expected_results.push_back(r);
    end

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      st = setting_at(p);
      wait_results();
      load_setting(st);
      resync = 1;
      start  = bytes_sent;
      while (bytes_sent - start < RANDOM_PER_SETTING) begin
        // Long master-side hold while bytes keep coming.
        if (p == 2 && !hold_done && bytes_sent - start > 40) begin
          hold_request = LONG_HOLD;
          hold_done    = 1;
        end
        // Pause the sender until the block has handed back everything.
        if (p == 3 && !pause_done && bytes_sent - start > 100) begin
          wait_results();
          pause_done = 1;
        end
        send_random_frame();
      end
    end
    wait_results();

    $display("Sent %0d bytes: reset defaults, then %0d register settings in both modes,",
             bytes_sent, NUM_SETTINGS);
    $display("with stalls on both sides; %0d frames closed, %0d of them by length overflow.",
             frames_closed, overflows);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mfd_pkg.sv
hdl/mfd_crc_step.sv
hdl/mfd_parser.sv
hdl/modbus_frame_delimiter_crc_unit.sv
tb/sv/tb_modbus_frame_delimiter_crc_unit.sv
